@@ design/sst_pkg.sv @@
// Shared types and constants of the shot split time recorder.
// No dependencies; used by sst_div1000 and shot_split_time_recorder.
package sst_pkg;

  localparam int unsigned MAX_SHOTS_DEF = 64;

  // Function codes of the input item.
  localparam logic [2:0] FUNC_BEGIN   = 3'd0;
  localparam logic [2:0] FUNC_SHOT    = 3'd1;
  localparam logic [2:0] FUNC_END     = 3'd2;
  localparam logic [2:0] FUNC_ELAPSED = 3'd3;
  localparam logic [2:0] FUNC_SPLIT   = 3'd4;

  // Numerator of the divide by 1000, clamped: anything at or above 2^42 us
  // saturates every result that is taken from it.
  localparam int unsigned NUM_W = 42;
  localparam int unsigned QUO_W = 33;

  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
  localparam logic [9:0]  ROUND_HALF_US = 10'd500;

  // n/1000 = x/125 with x = n >> 3 = xh * 2^20 + xl,
  // and 2^20 = 125 * 8388 + 76.
  localparam logic [13:0] DIV_HI_Q = 14'd8388;
  localparam logic [6:0]  DIV_HI_R = 7'd76;
  // ceil(2^33 / 125): exact floor(y / 125) for any y below 2^26
  localparam logic [26:0] DIV_RECIP = 27'd68719477;
  localparam int unsigned DIV_SHIFT = 33;

  typedef struct packed {
    logic en_a;  // numerator register to first stage
    logic en_b;  // first stage to second stage
  } sst_div_ctrl_t;

endpackage

@@ design/sst_div1000.sv @@
// Two-stage pipelined divide by 1000 of a 42-bit numerator.
// Depends on sst_pkg for widths, the reciprocal and the control struct.
module sst_div1000 (
  input  logic                         clk_i,
  input  sst_pkg::sst_div_ctrl_t       ctrl_i,
  input  logic [sst_pkg::NUM_W-1:0]    num_i,
  output logic [sst_pkg::QUO_W-1:0]    quo_o
);
  import sst_pkg::*;

  logic [18:0] xh;
  logic [19:0] xl;
  logic [25:0] y_d, y_q;
  logic [QUO_W-1:0] qh_a_d, qh_a_q, qh_b_q;
  logic [52:0] prod_q;

  assign xh = num_i[NUM_W-1:23];
  assign xl = num_i[22:3];

  // remainder part of the high half folded into the low half
  assign y_d    = {7'd0, xh} * {19'd0, DIV_HI_R} + {6'd0, xl};
  assign qh_a_d = {14'd0, xh} * {19'd0, DIV_HI_Q};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.en_a) begin
      y_q    <= y_d;
      qh_a_q <= qh_a_d;
    end
    if (ctrl_i.en_b) begin
      prod_q <= 53'(y_q) * 53'(DIV_RECIP);
      qh_b_q <= qh_a_q;
    end
  end

  assign quo_o = qh_b_q + QUO_W'(prod_q[52:DIV_SHIFT]);

endmodule

@@ design/shot_split_time_recorder.sv @@
// Shot split time recorder: top level with the shot store memory.
// Depends on sst_pkg and sst_div1000.
//
// Input channel (in_valid_i / in_stall_o) carries one item per command:
// begin string, shot, end string, elapsed query or split query. Output
// channel (out_valid_o / out_stall_i) returns one result item per input
// item, in order, with the query value and the string status after it.
// The user must write mic_offset_ms (cfg_we_i / cfg_wdata_i) only while
// idle; the block does not enforce it.
// Five register stages (input, delta, two divider stages, result) move
// one item per cycle while the receiver does not stall, so an item can
// then be taken every cycle; the divide by 1000 runs as two pipelined
// multiply stages. The MAX_SHOTS-entry (64 by default) shot store is
// read at two addresses one stage ahead of the update, with a bypass for
// the shot written in the same cycle.
// Reset empties the pipeline, closes the string and clears the status.
// The store needs no clearing: it is only read below the shot count.
// When the receiver stalls, the result holds and the stages behind fill
// up; in_stall_o rises only once every stage holds an item.
module shot_split_time_recorder #(
  parameter int unsigned MAX_SHOTS = sst_pkg::MAX_SHOTS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic signed [14:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         func_i,
  input  logic [31:0]        string_id_i,
  input  logic signed [63:0] time_us_i,
  input  logic [5:0]         shot_index_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        value_ms_o,
  output logic [6:0]         shot_count_o,
  output logic               string_open_o,
  output logic               overflow_flag_o,
  output logic [30:0]        first_shot_ms_o,
  output logic [30:0]        last_shot_ms_o,
  output logic [31:0]        best_split_ms_o,
  output logic [31:0]        worst_split_ms_o,
  output logic [31:0]        current_id_o
);
  import sst_pkg::*;

  localparam int unsigned AW = (MAX_SHOTS > 1) ? $clog2(MAX_SHOTS) : 1;
  localparam int unsigned CW = $clog2(MAX_SHOTS + 1);

  // pipeline control
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic en1, en2, en3, en4, en_out, fire4;

  // stage payloads
  logic [2:0]         func1_q, func2_q, func3_q, func4_q;
  logic [31:0]        id1_q, id2_q, id3_q, id4_q;
  logic [5:0]         idx1_q, idx2_q, idx3_q, idx4_q;
  logic signed [63:0] t1_q;
  logic               neg2_q, neg3_q, neg4_q;
  logic [NUM_W-1:0]   num_d, num2_q;

  // state
  logic signed [14:0] mic_off_q;
  logic signed [63:0] beep_q;
  logic [31:0]        run_id_q, run_id_d;
  logic [CW-1:0]      total_q, total_d;
  logic               accepting_q, accepting_d;
  logic               overflowed_q, overflowed_d;
  logic [31:0]        best_q, best_d, worst_q, worst_d;
  logic [30:0]        first_q, first_d, last_q, last_d;
  logic [31:0]        value_q, value_d;

  // shot store
  logic [30:0]   shot_mem_q [MAX_SHOTS];
  logic [30:0]   rd0_q, rd1_q, byp_q;
  logic          hit0_q, hit1_q;
  logic [AW-1:0] rd_addr0, rd_addr1, wr_addr;
  logic          wr_en;
  logic [30:0]   wr_data;

  logic               neg1;
  logic [63:0]        delta;
  logic [64:0]        num_wide;
  logic [QUO_W-1:0]   quo;
  sst_div_ctrl_t      div_ctrl;

  assign en_out     = !out_v_q || !out_stall_i;
  assign en4        = !v4_q || en_out;
  assign en3        = !v3_q || en4;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign fire4      = v4_q && en_out;
  assign in_stall_o = !en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1)    v1_q    <= in_valid_i;
      if (en2)    v2_q    <= v1_q;
      if (en3)    v3_q    <= v2_q;
      if (en4)    v4_q    <= v3_q;
      if (en_out) out_v_q <= v4_q;
    end
  end

  // delta against the beep; the beep is taken here so later items see it
  assign neg1     = t1_q < beep_q;
  assign delta    = 64'(t1_q - beep_q);
  assign num_wide = {1'b0, delta}
                  + ((func1_q == FUNC_SHOT) ? 65'(ROUND_HALF_US) : 65'd0);
  assign num_d    = (|num_wide[64:NUM_W]) ? '1 : num_wide[NUM_W-1:0];

  always_ff @(posedge clk_i) begin
    if (en1) begin
      func1_q <= func_i;
      id1_q   <= string_id_i;
      t1_q    <= time_us_i;
      idx1_q  <= shot_index_i;
    end
    if (en2) begin
      func2_q <= func1_q;
      id2_q   <= id1_q;
      idx2_q  <= idx1_q;
      neg2_q  <= neg1;
      num2_q  <= num_d;
    end
    if (en3) begin
      func3_q <= func2_q;
      id3_q   <= id2_q;
      idx3_q  <= idx2_q;
      neg3_q  <= neg2_q;
    end
    if (en4) begin
      func4_q <= func3_q;
      id4_q   <= id3_q;
      idx4_q  <= idx3_q;
      neg4_q  <= neg3_q;
    end
  end

  assign div_ctrl.en_a = en3;
  assign div_ctrl.en_b = en4;

  sst_div1000 u_div (
    .clk_i  (clk_i),
    .ctrl_i (div_ctrl),
    .num_i  (num2_q),
    .quo_o  (quo)
  );

  // store reads issue one stage ahead of the update
  assign rd_addr0 = AW'(idx3_q);
  assign rd_addr1 = AW'(idx3_q - 6'd1);

  always_ff @(posedge clk_i) begin
    if (wr_en) shot_mem_q[wr_addr] <= wr_data;
    if (en4) begin
      rd0_q  <= shot_mem_q[rd_addr0];
      rd1_q  <= shot_mem_q[rd_addr1];
      hit0_q <= wr_en && (wr_addr == rd_addr0);
      hit1_q <= wr_en && (wr_addr == rd_addr1);
      byp_q  <= wr_data;
    end
  end

  // update stage
  logic signed [34:0] ms_sum;
  logic [30:0]        shot_ms;
  logic [31:0]        split_new, cur0, cur1;
  logic               full;

  assign ms_sum   = $signed({2'b00, quo}) + {{20{mic_off_q[14]}}, mic_off_q};
  assign shot_ms  = (neg4_q || ms_sum[34]) ? 31'd0
                  : (|ms_sum[33:31]) ? MAX31 : ms_sum[30:0];
  assign split_new = {1'b0, shot_ms} - {1'b0, last_q};
  assign full     = (total_q == CW'(MAX_SHOTS));
  assign cur0     = {1'b0, hit0_q ? byp_q : rd0_q};
  assign cur1     = {1'b0, hit1_q ? byp_q : rd1_q};
  assign wr_addr  = AW'(total_q);
  assign wr_data  = shot_ms;
  assign wr_en    = fire4 && (func4_q == FUNC_SHOT) && accepting_q && !full;

  always_comb begin
    run_id_d     = run_id_q;
    total_d      = total_q;
    accepting_d  = accepting_q;
    overflowed_d = overflowed_q;
    best_d       = best_q;
    worst_d      = worst_q;
    first_d      = first_q;
    last_d       = last_q;
    value_d      = 32'd0;
    unique case (func4_q)
      FUNC_BEGIN: begin
        run_id_d     = id4_q;
        total_d      = '0;
        accepting_d  = 1'b1;
        overflowed_d = 1'b0;
        best_d       = '1;
        worst_d      = '0;
      end
      FUNC_SHOT: begin
        if (accepting_q) begin
          if (full) begin
            overflowed_d = 1'b1;
          end else begin
            if (total_q != '0) begin
              if (split_new < best_q)  best_d  = split_new;
              if (split_new > worst_q) worst_d = split_new;
            end else begin
              first_d = shot_ms;
            end
            last_d  = shot_ms;
            total_d = total_q + CW'(1);
          end
        end
      end
      FUNC_END: begin
        accepting_d = 1'b0;
      end
      FUNC_ELAPSED: begin
        if (!neg4_q) value_d = quo[QUO_W-1] ? '1 : quo[31:0];
      end
      FUNC_SPLIT: begin
        if (32'(idx4_q) < 32'(total_q)) begin
          value_d = (idx4_q == 6'd0) ? cur0 : cur0 - cur1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mic_off_q    <= '0;
      beep_q       <= '0;
      run_id_q     <= '0;
      total_q      <= '0;
      accepting_q  <= 1'b0;
      overflowed_q <= 1'b0;
      best_q       <= '1;
      worst_q      <= '0;
      first_q      <= '0;
      last_q       <= '0;
    end else begin
      if (cfg_we_i) mic_off_q <= cfg_wdata_i;
      if (en2 && v1_q && (func1_q == FUNC_BEGIN)) beep_q <= t1_q;
      if (fire4) begin
        run_id_q     <= run_id_d;
        total_q      <= total_d;
        accepting_q  <= accepting_d;
        overflowed_q <= overflowed_d;
        best_q       <= best_d;
        worst_q      <= worst_d;
        first_q      <= first_d;
        last_q       <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire4) value_q <= value_d;
  end

  // status registers change only when a result is loaded, so they match it
  assign out_valid_o      = out_v_q;
  assign value_ms_o       = value_q;
  assign shot_count_o     = 7'(total_q);
  assign string_open_o    = accepting_q;
  assign overflow_flag_o  = overflowed_q;
  assign first_shot_ms_o  = (total_q != '0) ? first_q : 31'd0;
  assign last_shot_ms_o   = (total_q != '0) ? last_q : 31'd0;
  assign best_split_ms_o  = (total_q >= CW'(2)) ? best_q : 32'd0;
  assign worst_split_ms_o = (total_q >= CW'(2)) ? worst_q : 32'd0;
  assign current_id_o     = run_id_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(total_q) <= MAX_SHOTS)
    else $error("shot count beyond store depth");

  a_overflow_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflowed_q |-> full)
    else $error("overflow set with room in the store");

  a_split_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (total_q >= CW'(2)) |-> (best_q <= worst_q))
    else $error("best split above worst split");

  a_stall_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (v1_q && v2_q && v3_q && v4_q && out_v_q))
    else $error("input stalled with a free stage");

endmodule
